// ===== hw/rtl/linear_queue_with_inplace_sort_top_assert.svh =====
// assertion macros for the queue with in-place sort
`ifndef LINEAR_QUEUE_WITH_INPLACE_SORT_TOP_ASSERT_SVH
`define LINEAR_QUEUE_WITH_INPLACE_SORT_TOP_ASSERT_SVH

// condition holds on every clock edge outside reset
`define LQS_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("lqs assertion failed");

// antecedent in one cycle implies consequent in the same cycle
`define LQS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lqs assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define LQS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lqs assertion failed");

`endif

// ===== hw/rtl/lqs_pkg.sv =====
// shared types and codes for the queue with in-place sort
package lqs_pkg;

  localparam int unsigned DataW = 32;

  // request codes
  localparam logic [2:0] REQ_ENQ  = 3'd0;
  localparam logic [2:0] REQ_DEQ  = 3'd1;
  localparam logic [2:0] REQ_PEEK = 3'd2;
  localparam logic [2:0] REQ_SORT = 3'd3;
  localparam logic [2:0] REQ_DUMP = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_OVF   = 2'd1;
  localparam logic [1:0] STATUS_UNDER = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_DUMP
  } lqs_state_e;

  // control broadcast to every cell
  typedef struct packed {
    logic                    sort_en;
    logic                    phase;
    logic                    wr_en;
    logic signed [DataW-1:0] wr_data;
  } lqs_ctrl_t;

endpackage

// ===== hw/rtl/linear_queue_with_inplace_sort_top.sv =====
// top level: linear queue of signed words held in a row of sorting cells
//
// Requests enter on start/req_type_i/data_in_i and are taken at a rising edge
// where start is high and busy is low. Every result appears on the result
// ports for exactly one cycle, marked by res_strobe_o; the receiver cannot
// stall, so each strobe is one transaction taken as it goes by.
// Enqueue, dequeue and peek: one result, in the cycle after the request.
// Sort on a non-empty queue: the cells run DEPTH+1 rounds of odd-even
// compare-exchange over the live range, busy is high for that time and the
// single result is registered at the end of the last round.
// Dump on a non-empty queue: one result per live entry on consecutive
// cycles, each slot read in the dump state and then registered, last_o on
// the final one; the read of one slot per cycle through the output mux
// sets that pace. Empty-queue sort and dump answer in the cycle after the
// request; unused request codes give no result.
// Reset empties the queue (head and tail at zero); slot contents are not
// cleared and are only read once written.
module linear_queue_with_inplace_sort_top import lqs_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              req_type_i,
  input  logic signed [DataW-1:0] data_in_i,
  output logic                    res_strobe_o,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] value_o,
  output logic                    value_valid_o,
  output logic                    last_o
);

  `include "linear_queue_with_inplace_sort_top_assert.svh"

  localparam int unsigned IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [IW:0] LastRound = (IW+1)'(DEPTH);

  lqs_state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic          empty_q, empty_d;
  logic [IW:0]   cnt_q, cnt_d;

  logic                    strobe_q, strobe_d;
  logic [1:0]              status_q, status_d;
  logic signed [DataW-1:0] value_q, value_d;
  logic                    vvalid_q, vvalid_d;
  logic                    last_q, last_d;

  lqs_ctrl_t               ctrl;
  logic [IW-1:0]           wr_idx;
  logic [IW-1:0]           rd_idx;
  logic signed [DataW-1:0] rd_val;
  logic                    accept;
  logic                    dump_end;
  logic                    sort_end;

  logic signed [DataW-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]        cell_swap;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_val;
    logic signed [DataW-1:0] right_val;
    logic                    left_swap;

    if (i == 0) begin : g_first
      assign left_val  = cell_val[i];
      assign left_swap = 1'b0;
    end else begin : g_mid
      assign left_val  = cell_val[i-1];
      assign left_swap = cell_swap[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    lqs_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .wr_idx_i    (wr_idx),
      .lo_i        (head_q),
      .hi_i        (tail_q),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .left_swap_i (left_swap),
      .val_o       (cell_val[i]),
      .swap_o      (cell_swap[i])
    );
  end

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign rd_idx   = (state_q == ST_DUMP) ? cnt_q[IW-1:0] : head_q;
  assign rd_val   = cell_val[rd_idx];
  assign dump_end = (cnt_q[IW-1:0] == tail_q);
  assign sort_end = (cnt_q == LastRound);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !empty_q && req_type_i == REQ_SORT) begin
          state_d = ST_SORT;
        end else if (accept && !empty_q && req_type_i == REQ_DUMP) begin
          state_d = ST_DUMP;
        end
      end
      ST_SORT: begin
        if (sort_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (dump_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    cnt_d        = cnt_q;
    strobe_d     = 1'b0;
    status_d     = status_q;
    value_d      = value_q;
    vvalid_d     = vvalid_q;
    last_d       = last_q;
    ctrl.sort_en = 1'b0;
    ctrl.phase   = cnt_q[0];
    ctrl.wr_en   = 1'b0;
    ctrl.wr_data = data_in_i;
    wr_idx       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STATUS_OK;
          value_d  = '0;
          vvalid_d = 1'b0;
          last_d   = 1'b1;
          case (req_type_i)
            REQ_ENQ: begin
              strobe_d = 1'b1;
              if (empty_q) begin
                head_d     = '0;
                tail_d     = '0;
                empty_d    = 1'b0;
                ctrl.wr_en = 1'b1;
                wr_idx     = '0;
              end else if (tail_q == LastIdx) begin
                status_d = STATUS_OVF;
              end else begin
                tail_d     = tail_q + IW'(1);
                ctrl.wr_en = 1'b1;
                wr_idx     = tail_q + IW'(1);
              end
            end
            REQ_DEQ: begin
              strobe_d = 1'b1;
              if (empty_q) begin
                status_d = STATUS_UNDER;
              end else begin
                value_d  = rd_val;
                vvalid_d = 1'b1;
                if (head_q >= tail_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b1;
                end else begin
                  head_d = head_q + IW'(1);
                end
              end
            end
            REQ_PEEK: begin
              strobe_d = 1'b1;
              if (empty_q) begin
                status_d = STATUS_EMPTY;
              end else begin
                value_d  = rd_val;
                vvalid_d = 1'b1;
              end
            end
            REQ_SORT: begin
              if (empty_q) begin
                strobe_d = 1'b1;
              end else begin
                cnt_d = '0;
              end
            end
            REQ_DUMP: begin
              if (empty_q) begin
                strobe_d = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                cnt_d = {1'b0, head_q};
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SORT: begin
        ctrl.sort_en = 1'b1;
        cnt_d        = cnt_q + (IW+1)'(1);
        if (sort_end) begin
          strobe_d = 1'b1;
          status_d = STATUS_OK;
          value_d  = '0;
          vvalid_d = 1'b0;
          last_d   = 1'b1;
        end
      end
      ST_DUMP: begin
        strobe_d = 1'b1;
        status_d = STATUS_OK;
        value_d  = rd_val;
        vvalid_d = 1'b1;
        last_d   = dump_end;
        cnt_d    = cnt_q + (IW+1)'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    value_q  <= value_d;
    vvalid_q <= vvalid_d;
    last_q   <= last_d;
  end

  assign res_strobe_o  = strobe_q;
  assign status_o      = status_q;
  assign value_o       = value_q;
  assign value_valid_o = vvalid_q;
  assign last_o        = last_q;

  `LQS_ASSERT_ALWAYS(a_live_order, empty_q || (head_q <= tail_q))
  `LQS_ASSERT_IMPL(a_sort_needs_data, state_q == ST_SORT, !empty_q)
  `LQS_ASSERT_IMPL(a_entry_ok, res_strobe_o && value_valid_o, status_o == STATUS_OK)
  `LQS_ASSERT_NEXT(a_dump_last, (state_q == ST_DUMP) && dump_end,
                   res_strobe_o && last_o && (state_q == ST_IDLE))
  `LQS_ASSERT_NEXT(a_unused_silent, accept && (req_type_i > REQ_DUMP), !res_strobe_o)

endmodule

// ===== hw/rtl/lqs_cell.sv =====
// one slot of the queue with its compare-exchange against the right neighbour
module lqs_cell import lqs_pkg::*; #(
  parameter int unsigned IW  = 3,
  parameter int unsigned IDX = 0
) (
  input  logic                    clk_i,
  input  lqs_ctrl_t               ctrl_i,
  input  logic [IW-1:0]           wr_idx_i,
  input  logic [IW-1:0]           lo_i,
  input  logic [IW-1:0]           hi_i,
  input  logic signed [DataW-1:0] left_val_i,
  input  logic signed [DataW-1:0] right_val_i,
  input  logic                    left_swap_i,
  output logic signed [DataW-1:0] val_o,
  output logic                    swap_o
);

  localparam logic [IW:0] IdxW  = (IW+1)'(IDX);
  localparam logic [IW:0] NextW = (IW+1)'(IDX + 1);
  localparam logic        Par   = 1'(IDX % 2);

  logic signed [DataW-1:0] val_q, val_d;
  logic                    in_pair;
  logic                    wr_hit;

  // this cell leads the pair (IDX, IDX+1) when both lie in the live range
  assign in_pair = ({1'b0, lo_i} <= IdxW) && (NextW <= {1'b0, hi_i});
  assign swap_o  = ctrl_i.sort_en && (ctrl_i.phase == Par) && in_pair &&
                   (val_q > right_val_i);
  assign wr_hit  = ctrl_i.wr_en && (wr_idx_i == IdxW[IW-1:0]);

  always_comb begin
    val_d = val_q;
    if (wr_hit) begin
      val_d = ctrl_i.wr_data;
    end else if (swap_o) begin
      val_d = right_val_i;
    end else if (left_swap_i) begin
      val_d = left_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
